>>> rtl/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// shared types, codes and constants of the periodic task dispatcher
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int CFG_IDX_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_COMP_WINDOW = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_FIRST  = CFG_IDX_W'(1);

  localparam logic [31:0] COMP_WINDOW_RST = 32'd1000;
  localparam logic [63:0] WAIT_NONE       = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_CREATE = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_ENABLE = 3'd3,
    REQ_DELAY  = 3'd4,
    REQ_QUERY  = 3'd5,
    REQ_NOP    = 3'd6,
    REQ_RSVD   = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_LATE,
    ST_ADV,
    ST_SLOT_WR,
    ST_FINISH
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] period;
    logic [63:0] due;
  } entry_t;

endpackage

>>> rtl/ptd_ifc.sv
// ----------------------------------------------------------------------------
// ptd interfaces
// request, result and configuration channels of the dispatcher
// ----------------------------------------------------------------------------
interface ptd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [3:0]  slot;
  logic [63:0] now_ticks;
  logic [31:0] period_ticks;
  logic [7:0]  prio_level;
  logic        enable_flag;
  logic [31:0] delay_ticks;
  logic        delay_mode;
  modport source (output valid, req_type, slot, now_ticks, period_ticks, prio_level,
                  enable_flag, delay_ticks, delay_mode, input ready);
  modport sink (input valid, req_type, slot, now_ticks, period_ticks, prio_level,
                enable_flag, delay_ticks, delay_mode, output ready);
endinterface

interface ptd_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic        run_valid;
  logic [3:0]  run_slot;
  logic [63:0] wait_ticks;
  logic        slot_exists;
  logic        slot_enabled;
  logic [4:0]  task_count;
  modport source (output valid, status, run_valid, run_slot, wait_ticks, slot_exists,
                  slot_enabled, task_count, input ready);
  modport sink (input valid, status, run_valid, run_slot, wait_ticks, slot_exists,
                slot_enabled, task_count, output ready);
endinterface

interface ptd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  idx;
  logic [63:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

>>> rtl/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// periodic task slot table with priority dispatch on tick items
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type slot now_ticks period_ticks prio_level
//                               enable_flag delay_ticks delay_mode
//  rsp      out  valid/ready    status run_valid run_slot wait_ticks slot_exists
//                               slot_enabled task_count
//  cfg      in   valid/ready    idx data (always ready)
//
//  tick item: decode, scan of all slots, late check, due advance when a task is dispatched, result
//  other items: decode, optional read-modify-write, result
//  req is ready only in idle; result sits in an output register
//  the result is held while rsp stalls; the next item waits for a free register
//  rst clears valid and enable bits, task count, state, configuration and rsp valid, no table sweep
// ----------------------------------------------------------------------------
module periodic_task_dispatcher import ptd_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst,
  ptd_req_if.sink    req,
  ptd_rsp_if.source  rsp,
  ptd_cfg_if.sink    cfg
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  state_t state, state_next;

  logic [31:0]          comp_window;
  logic                 high_first;
  logic [NUM_SLOTS-1:0] valid;
  logic [NUM_SLOTS-1:0] enable;
  logic [CW-1:0]        cnt;

  logic [2:0]  q_type;
  logic [3:0]  q_slot;
  logic [63:0] q_now;
  logic [31:0] q_period;
  logic [7:0]  q_prio;
  logic        q_en;
  logic [31:0] q_delay;
  logic        q_from;

  logic [CW-1:0] scan_cnt;
  logic          ev_vld;
  logic [SW-1:0] ev_idx;
  logic          found;
  logic          any;
  logic [SW-1:0] best_idx;
  logic [7:0]    best_prio;
  logic [31:0]   best_period;
  logic [63:0]   best_due;
  logic [63:0]   earliest;
  logic          adv;

  logic        res_status;
  logic        res_run;
  logic [63:0] res_wait;
  logic        res_exists;
  logic        res_enabled;

  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [SW-1:0] mem_raddr;
  entry_t        mem_wdata;
  entry_t        mem_rdata;
  alu_req_t      alu_in;
  logic [63:0]   alu_y;

  logic [SW-1:0] q_si;
  logic          q_in_range;
  logic          q_present;
  logic          better;

  assign q_si       = SW'(q_slot);
  assign q_in_range = (32'(q_slot) < NUM_SLOTS);
  assign q_present  = q_in_range && valid[q_si];
  assign better     = high_first ? (mem_rdata.prio > best_prio) : (mem_rdata.prio < best_prio);

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  ptd_mem #(.NUM_SLOTS(NUM_SLOTS), .SW(SW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ptd_alu u_alu (
    .ctl (alu_in),
    .y   (alu_y)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      comp_window <= COMP_WINDOW_RST;
      high_first  <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.idx == CFG_COMP_WINDOW) begin
        comp_window <= cfg.data[31:0];
      end else if (cfg.idx == CFG_HIGH_FIRST) begin
        high_first <= cfg.data[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = q_si;
    mem_raddr  = q_si;
    mem_wdata  = '{prio: q_prio, period: (q_period == 32'd0) ? 32'd1 : q_period, due: q_now};
    alu_in     = '{op: ALU_ADD, a: q_now, b: 64'd0};
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (q_type == REQ_TICK) begin
          state_next = ST_SCAN;
        end else if (q_type == REQ_CREATE && q_in_range) begin
          mem_we     = 1'b1;
          state_next = ST_FINISH;
        end else if (q_present &&
                     ((q_type == REQ_ENABLE && q_en) || q_type == REQ_DELAY)) begin
          state_next = ST_SLOT_WR;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_SCAN: begin
        mem_raddr = scan_cnt[SW-1:0];
        if (scan_cnt == CW'(NUM_SLOTS) && !ev_vld) begin
          state_next = ST_LATE;
        end
      end
      ST_LATE: begin
        if (found) begin
          alu_in     = '{op: ALU_SUB, a: q_now, b: best_due};
          state_next = ST_ADV;
        end else begin
          alu_in     = '{op: ALU_SUB, a: earliest, b: q_now};
          state_next = ST_FINISH;
        end
      end
      ST_ADV: begin
        alu_in     = '{op: ALU_ADD, a: adv ? best_due : q_now, b: {32'd0, best_period}};
        mem_we     = 1'b1;
        mem_waddr  = best_idx;
        mem_wdata  = '{prio: best_prio, period: best_period, due: alu_y};
        state_next = ST_FINISH;
      end
      ST_SLOT_WR: begin
        alu_in = '{op: ALU_ADD, a: q_from ? q_now : mem_rdata.due, b: {32'd0, q_delay}};
        mem_we = 1'b1;
        if (q_type == REQ_DELAY) begin
          mem_wdata = '{prio: mem_rdata.prio, period: mem_rdata.period, due: alu_y};
        end else begin
          mem_wdata = '{prio: mem_rdata.prio, period: mem_rdata.period, due: q_now};
        end
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // slot valid and enable bits, task count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      enable <= '0;
      cnt    <= '0;
    end else if (state == ST_DECODE) begin
      if (q_type == REQ_CREATE && q_in_range) begin
        if (!valid[q_si]) begin
          cnt <= cnt + 1'b1;
        end
        valid[q_si]  <= 1'b1;
        enable[q_si] <= q_en;
      end else if (q_type == REQ_DELETE && q_present) begin
        valid[q_si]  <= 1'b0;
        enable[q_si] <= 1'b0;
        cnt          <= cnt - 1'b1;
      end else if (q_type == REQ_ENABLE && q_present) begin
        enable[q_si] <= q_en;
      end
    end
  end

  // item fields, scan and result registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          q_type   <= req.req_type;
          q_slot   <= req.slot;
          q_now    <= req.now_ticks;
          q_period <= req.period_ticks;
          q_prio   <= req.prio_level;
          q_en     <= req.enable_flag;
          q_delay  <= req.delay_ticks;
          q_from   <= req.delay_mode;
        end
      end
      ST_DECODE: begin
        scan_cnt    <= '0;
        ev_vld      <= 1'b0;
        found       <= 1'b0;
        any         <= 1'b0;
        best_idx    <= '0;
        res_run     <= 1'b0;
        res_wait    <= 64'd0;
        res_exists  <= (q_type == REQ_QUERY) && q_present;
        res_enabled <= (q_type == REQ_QUERY) && q_present && enable[q_si];
        if (q_type == REQ_CREATE) begin
          res_status <= !q_in_range;
        end else if (q_type == REQ_DELETE || q_type == REQ_ENABLE ||
                     q_type == REQ_DELAY || q_type == REQ_QUERY) begin
          res_status <= !q_present;
        end else begin
          res_status <= 1'b0;
        end
      end
      ST_SCAN: begin
        if (scan_cnt < CW'(NUM_SLOTS)) begin
          ev_vld   <= 1'b1;
          ev_idx   <= scan_cnt[SW-1:0];
          scan_cnt <= scan_cnt + 1'b1;
        end else begin
          ev_vld <= 1'b0;
        end
        if (ev_vld && valid[ev_idx] && enable[ev_idx]) begin
          any <= 1'b1;
          if (!any || mem_rdata.due < earliest) begin
            earliest <= mem_rdata.due;
          end
          if (q_now >= mem_rdata.due) begin
            found <= 1'b1;
            if (!found || better) begin
              best_idx    <= ev_idx;
              best_prio   <= mem_rdata.prio;
              best_period <= mem_rdata.period;
              best_due    <= mem_rdata.due;
            end
          end
        end
      end
      ST_LATE: begin
        adv     <= (alu_y <= {32'd0, comp_window});
        res_run <= found;
        if (found) begin
          res_wait <= 64'd0;
        end else if (any) begin
          res_wait <= alu_y;
        end else begin
          res_wait <= WAIT_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!rsp.valid || rsp.ready)) begin
      rsp.status       <= res_status;
      rsp.run_valid    <= res_run;
      rsp.run_slot     <= res_run ? 4'(best_idx) : 4'd0;
      rsp.wait_ticks   <= res_wait;
      rsp.slot_exists  <= res_exists;
      rsp.slot_enabled <= res_enabled;
      rsp.task_count   <= 5'(cnt);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an item is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(NUM_SLOTS))
    else $error("task count beyond slot count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_cnt <= CW'(NUM_SLOTS))
    else $error("scan ran past the table");

  a_run_no_wait: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.run_valid |-> rsp.wait_ticks == 64'd0)
    else $error("dispatch result carries a wait");

endmodule

>>> rtl/ptd_mem.sv
// ----------------------------------------------------------------------------
// ptd_mem
// slot table: priority, period and due time, one write and one read port
// ----------------------------------------------------------------------------
module ptd_mem import ptd_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int SW        = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [SW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [SW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ptd_alu.sv
// ----------------------------------------------------------------------------
// ptd_alu
// shared 64-bit add / subtract unit for due time and wait arithmetic
// ----------------------------------------------------------------------------
module ptd_alu import ptd_pkg::*; (
  input  alu_req_t    ctl,
  output logic [63:0] y
);

  always_comb begin
    case (ctl.op)
      ALU_ADD: y = ctl.a + ctl.b;
      ALU_SUB: y = ctl.a - ctl.b;
      default: y = ctl.a;
    endcase
  end

endmodule
